### hdl/sfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

	localparam int unsigned NUM_PLANES_DEF = 6;

	localparam int unsigned PLANE_IDX_W = 3;
	localparam int unsigned COEF_IDX_W  = 2;
	localparam int unsigned AXIS_W      = 2;
	localparam int unsigned VIS_W       = 2;

	localparam int unsigned Q_W        = 32;
	localparam int unsigned R_W        = 31;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned PROD_W     = 2 * Q_W;
	localparam int unsigned FLR_W      = PROD_W - FRAC_W;
	localparam int unsigned DIST_W     = FLR_W + 2;
	localparam int unsigned RPROD_W    = 2 * R_W;
	localparam int unsigned RAD_FLR_W  = RPROD_W - FRAC_W;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TEST  = 1'b1;

	localparam logic [COEF_IDX_W-1:0] COEF_A = 2'd0;
	localparam logic [COEF_IDX_W-1:0] COEF_B = 2'd1;
	localparam logic [COEF_IDX_W-1:0] COEF_C = 2'd2;
	localparam logic [COEF_IDX_W-1:0] COEF_D = 2'd3;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

	localparam logic [VIS_W-1:0] VIS_OUTSIDE   = 2'd0;
	localparam logic [VIS_W-1:0] VIS_INTERSECT = 2'd1;
	localparam logic [VIS_W-1:0] VIS_INSIDE    = 2'd2;

	typedef struct packed {
		logic signed [Q_W-1:0] a;
		logic signed [Q_W-1:0] b;
		logic signed [Q_W-1:0] c;
		logic signed [Q_W-1:0] d;
	} plane_coef_t;

	typedef struct packed {
		logic en2;
		logic en3;
	} pipe_en_t;

endpackage

`default_nettype wire

### hdl/sfc_plane_table.sv
`timescale 1ns / 1ps
`default_nettype none

module sfc_plane_table #(
	parameter int unsigned NUM_PLANES = sfc_pkg::NUM_PLANES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [sfc_pkg::PLANE_IDX_W-1:0]    wr_plane,
	input  wire logic [sfc_pkg::COEF_IDX_W-1:0]     wr_coef,
	input  wire logic signed [sfc_pkg::Q_W-1:0]     wr_value,
	output sfc_pkg::plane_coef_t                    planes [NUM_PLANES]
);

	sfc_pkg::plane_coef_t planes_q [NUM_PLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				planes_q[p] <= '0;
			end
		end else if (wr_en) begin
			// rows past the table never match, so such writes drop out
			for (int p = 0; p < NUM_PLANES; p++) begin
				if (wr_plane == sfc_pkg::PLANE_IDX_W'(p)) begin
					unique case (wr_coef)
						sfc_pkg::COEF_A: planes_q[p].a <= wr_value;
						sfc_pkg::COEF_B: planes_q[p].b <= wr_value;
						sfc_pkg::COEF_C: planes_q[p].c <= wr_value;
						default:         planes_q[p].d <= wr_value;
					endcase
				end
			end
		end
	end

	assign planes = planes_q;

endmodule

`default_nettype wire

### hdl/sfc_plane_dist.sv
`timescale 1ns / 1ps
`default_nettype none

module sfc_plane_dist (
	input  wire logic                               clk,
	input  wire sfc_pkg::pipe_en_t                  en,
	input  wire sfc_pkg::plane_coef_t               coefs,
	input  wire logic signed [sfc_pkg::Q_W-1:0]     cx_s1,
	input  wire logic signed [sfc_pkg::Q_W-1:0]     cy_s1,
	input  wire logic signed [sfc_pkg::Q_W-1:0]     cz_s1,
	output logic signed [sfc_pkg::DIST_W-1:0]       dist_s3
);

	logic signed [sfc_pkg::PROD_W-1:0] prod_x, prod_y, prod_z;
	logic signed [sfc_pkg::FLR_W-1:0]  px_s2, py_s2, pz_s2;
	logic signed [sfc_pkg::Q_W-1:0]    d_s2;
	logic signed [sfc_pkg::DIST_W-1:0] sum;

	assign prod_x = coefs.a * cx_s1;
	assign prod_y = coefs.b * cy_s1;
	assign prod_z = coefs.c * cz_s1;

	// floor to Q16.16 is an arithmetic shift, taken as the upper bits
	always_ff @(posedge clk) begin
		if (en.en2) begin
			px_s2 <= prod_x[sfc_pkg::PROD_W-1:sfc_pkg::FRAC_W];
			py_s2 <= prod_y[sfc_pkg::PROD_W-1:sfc_pkg::FRAC_W];
			pz_s2 <= prod_z[sfc_pkg::PROD_W-1:sfc_pkg::FRAC_W];
			d_s2  <= coefs.d;
		end
	end

	assign sum = sfc_pkg::DIST_W'(px_s2) + sfc_pkg::DIST_W'(py_s2)
	           + sfc_pkg::DIST_W'(pz_s2) + sfc_pkg::DIST_W'(d_s2);

	always_ff @(posedge clk) begin
		if (en.en3) begin
			dist_s3 <= sum;
		end
	end

endmodule

`default_nettype wire

### hdl/sphere_frustum_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Sphere versus frustum classifier. Takes one word per cycle unless stalled.
// A write word (op 0) stores one plane coefficient at acceptance and gives
// no result; writes to planes past the table are dropped. A test word
// (op 1) raises result_valid with its visibility code after the input,
// product (all plane products and scaled radius in parallel), sum and output
// registers, so back-to-back tests stream at one per cycle while result_stall
// is low. Every test sees all words accepted before it. A full stage stalls
// only when the next one does, so empty stages keep filling while a result
// waits. The plane table is cleared by reset and is ready right after it.
module sphere_frustum_classifier #(
	parameter int unsigned NUM_PLANES = sfc_pkg::NUM_PLANES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output logic                                    item_stall,
	input  wire logic                               op,
	input  wire logic [sfc_pkg::PLANE_IDX_W-1:0]    plane_index,
	input  wire logic [sfc_pkg::COEF_IDX_W-1:0]     coef_index,
	input  wire logic signed [sfc_pkg::Q_W-1:0]     coef_value,
	input  wire logic signed [sfc_pkg::Q_W-1:0]     center_x,
	input  wire logic signed [sfc_pkg::Q_W-1:0]     center_y,
	input  wire logic signed [sfc_pkg::Q_W-1:0]     center_z,
	input  wire logic [sfc_pkg::R_W-1:0]            base_radius,
	input  wire logic [sfc_pkg::R_W-1:0]            scale_x,
	input  wire logic [sfc_pkg::R_W-1:0]            scale_y,
	input  wire logic [sfc_pkg::R_W-1:0]            scale_z,
	input  wire logic [sfc_pkg::AXIS_W-1:0]         radius_axis,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic [sfc_pkg::VIS_W-1:0]               visibility
);

	logic en1, en2, en3, en4;
	logic accept;
	logic valid_s1, valid_s2, valid_s3, res_valid_q;
	sfc_pkg::pipe_en_t pipe_en;

	logic signed [sfc_pkg::Q_W-1:0] cx_s1, cy_s1, cz_s1;
	logic [sfc_pkg::R_W-1:0] base_s1, scale_s1, scale_sel;
	logic [sfc_pkg::RPROD_W-1:0] rad_prod;
	logic [sfc_pkg::RAD_FLR_W-1:0] rad_flr_s2;
	logic [sfc_pkg::R_W-1:0] radius_s3;

	sfc_pkg::plane_coef_t planes [NUM_PLANES];
	logic signed [sfc_pkg::DIST_W-1:0] dist_s3 [NUM_PLANES];
	logic signed [sfc_pkg::DIST_W-1:0] rad_ext, neg_rad;
	logic any_out, all_in;
	logic [sfc_pkg::VIS_W-1:0] vis_d, vis_q;

	assign en4 = !res_valid_q || !result_stall;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign item_stall = !en1;
	assign accept = item_valid && en1;
	assign pipe_en = '{en2: en2, en3: en3};

	sfc_plane_table #(
		.NUM_PLANES(NUM_PLANES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && (op == sfc_pkg::OP_WRITE)),
		.wr_plane(plane_index),
		.wr_coef (coef_index),
		.wr_value(coef_value),
		.planes  (planes)
	);

	always_comb begin
		case (radius_axis)
			sfc_pkg::AXIS_X: scale_sel = scale_x;
			sfc_pkg::AXIS_Y: scale_sel = scale_y;
			default:         scale_sel = scale_z;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= accept && (op == sfc_pkg::OP_TEST);
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				res_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			cx_s1    <= center_x;
			cy_s1    <= center_y;
			cz_s1    <= center_z;
			base_s1  <= base_radius;
			scale_s1 <= scale_sel;
		end
	end

	// table is read in the same cycle the test leaves stage 1
	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		sfc_plane_dist u_dist (
			.clk    (clk),
			.en     (pipe_en),
			.coefs  (planes[p]),
			.cx_s1  (cx_s1),
			.cy_s1  (cy_s1),
			.cz_s1  (cz_s1),
			.dist_s3(dist_s3[p])
		);
	end

	assign rad_prod = base_s1 * scale_s1;

	always_ff @(posedge clk) begin
		if (en2) begin
			rad_flr_s2 <= rad_prod[sfc_pkg::RPROD_W-1:sfc_pkg::FRAC_W];
		end
		if (en3) begin
			radius_s3 <= (|rad_flr_s2[sfc_pkg::RAD_FLR_W-1:sfc_pkg::R_W]) ?
			             {sfc_pkg::R_W{1'b1}} : rad_flr_s2[sfc_pkg::R_W-1:0];
		end
	end

	assign rad_ext = sfc_pkg::DIST_W'(radius_s3);
	assign neg_rad = -rad_ext;

	always_comb begin
		any_out = 1'b0;
		all_in  = 1'b1;
		for (int i = 0; i < NUM_PLANES; i++) begin
			if (dist_s3[i] <= neg_rad) begin
				any_out = 1'b1;
			end
			if (dist_s3[i] <= rad_ext) begin
				all_in = 1'b0;
			end
		end
		if (any_out) begin
			vis_d = sfc_pkg::VIS_OUTSIDE;
		end else if (all_in) begin
			vis_d = sfc_pkg::VIS_INSIDE;
		end else begin
			vis_d = sfc_pkg::VIS_INTERSECT;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			vis_q <= vis_d;
		end
	end

	assign result_valid = res_valid_q;
	assign visibility   = vis_q;

endmodule

`default_nettype wire

### hdl/sfc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sfc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            item_valid,
	input wire logic                            item_stall,
	input wire logic                            op,
	input wire logic                            result_valid,
	input wire logic                            result_stall,
	input wire logic [sfc_pkg::VIS_W-1:0]       visibility
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(visibility))
		else $error("result word changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (visibility == sfc_pkg::VIS_OUTSIDE ||
		                  visibility == sfc_pkg::VIS_INTERSECT ||
		                  visibility == sfc_pkg::VIS_INSIDE))
		else $error("visibility code out of range");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled with empty output");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && op == sfc_pkg::OP_TEST)
		##1 !result_stall ##1 !result_stall ##1 !result_stall |=> result_valid)
		else $error("test word gave no result after three cycles");

endmodule

bind sphere_frustum_classifier sfc_checker u_sfc_checker (.*);

`default_nettype wire

### dv/sphere_frustum_classifier_tb.sv
`timescale 1ns / 1ps

module sphere_frustum_classifier_tb;
	import sfc_pkg::*;

	localparam int PLANE_COUNT     = NUM_PLANES_DEF;
	localparam int COEFS_PER_PLANE = 4;
	localparam int RANDOM_UNTIL    = 940;
	localparam int DRAIN_CYCLES    = 12;
	localparam longint CYCLE_LIMIT = 400000;

	localparam logic [AXIS_W-1:0] AXIS_Z_SEL   = 2'd2;
	localparam logic [AXIS_W-1:0] AXIS_Z_ALIAS = 2'd3;

	localparam logic signed [Q_W-1:0] ONE   = 32'sh0001_0000;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic [R_W-1:0] R_ONE  = 31'h0001_0000;
	localparam logic [R_W-1:0] R_HALF = 31'h0000_8000;
	localparam logic [R_W-1:0] R_TWO  = 31'h0002_0000;
	localparam logic [R_W-1:0] R_MAX  = 31'h7FFF_FFFF;

	typedef struct {
		logic                    op;
		logic [PLANE_IDX_W-1:0]  plane;
		logic [COEF_IDX_W-1:0]   coef_sel;
		logic signed [Q_W-1:0]   coef;
		logic signed [Q_W-1:0]   cx;
		logic signed [Q_W-1:0]   cy;
		logic signed [Q_W-1:0]   cz;
		logic [R_W-1:0]          base;
		logic [R_W-1:0]          sx;
		logic [R_W-1:0]          sy;
		logic [R_W-1:0]          sz;
		logic [AXIS_W-1:0]       axis;
	} cull_word_t;

	typedef struct {
		logic [VIS_W-1:0] vis;
		int               serial;
	} vis_due_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    item_valid   = 1'b0;
	logic                    item_stall;
	logic                    op           = OP_WRITE;
	logic [PLANE_IDX_W-1:0]  plane_index  = '0;
	logic [COEF_IDX_W-1:0]   coef_index   = '0;
	logic signed [Q_W-1:0]   coef_value   = '0;
	logic signed [Q_W-1:0]   center_x     = '0;
	logic signed [Q_W-1:0]   center_y     = '0;
	logic signed [Q_W-1:0]   center_z     = '0;
	logic [R_W-1:0]          base_radius  = '0;
	logic [R_W-1:0]          scale_x      = '0;
	logic [R_W-1:0]          scale_y      = '0;
	logic [R_W-1:0]          scale_z      = '0;
	logic [AXIS_W-1:0]       radius_axis  = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic [VIS_W-1:0]        visibility;

	logic signed [Q_W-1:0] plane_coef [PLANE_COUNT*COEFS_PER_PLANE] = '{default: '0};
	vis_due_t vis_due [$];

	int     gap_pct     = 20;
	bit     steady      = 1'b0;
	int     word_count  = 0;
	int     test_serial = 0;
	int     error_count = 0;
	int     rx_left     = 0;
	longint cycle_count = 0;

	sphere_frustum_classifier #(
		.NUM_PLANES(PLANE_COUNT)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.op          (op),
		.plane_index (plane_index),
		.coef_index  (coef_index),
		.coef_value  (coef_value),
		.center_x    (center_x),
		.center_y    (center_y),
		.center_z    (center_z),
		.base_radius (base_radius),
		.scale_x     (scale_x),
		.scale_y     (scale_y),
		.scale_z     (scale_z),
		.radius_axis (radius_axis),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.visibility  (visibility)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		error_count++;
	endtask

	function automatic logic [VIS_W-1:0] classify_sphere(input cull_word_t w);
		logic [R_W-1:0] scale;
		longint unsigned rad_wide;
		longint radius;
		longint plane_dist;
		int inside_count;
		bit outside;
		int k;
		case (w.axis)
			AXIS_X:  scale = w.sx;
			AXIS_Y:  scale = w.sy;
			default: scale = w.sz;
		endcase
		rad_wide = (64'(w.base) * 64'(scale)) >> FRAC_W;
		radius = (rad_wide > 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(rad_wide);
		inside_count = 0;
		outside = 1'b0;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			k = p * COEFS_PER_PLANE;
			plane_dist = ((longint'(plane_coef[k + COEF_A]) * longint'(w.cx)) >>> FRAC_W)
				+ ((longint'(plane_coef[k + COEF_B]) * longint'(w.cy)) >>> FRAC_W)
				+ ((longint'(plane_coef[k + COEF_C]) * longint'(w.cz)) >>> FRAC_W)
				+ longint'(plane_coef[k + COEF_D]);
			if (plane_dist <= -radius)
				outside = 1'b1;
			else if (plane_dist > radius)
				inside_count++;
		end
		if (outside)
			return VIS_OUTSIDE;
		return (inside_count == PLANE_COUNT) ? VIS_INSIDE : VIS_INTERSECT;
	endfunction

	function automatic int jitter(input int amt);
		return int'($urandom_range(0, 2 * amt)) - amt;
	endfunction

	function automatic cull_word_t random_word();
		cull_word_t w;
		w.op       = $urandom_range(0, 1);
		w.plane    = $urandom_range(0, 7);
		w.coef_sel = $urandom_range(0, 3);
		w.coef     = $urandom();
		w.cx       = $urandom();
		w.cy       = $urandom();
		w.cz       = $urandom();
		w.base     = R_W'($urandom());
		w.sx       = R_W'($urandom());
		w.sy       = R_W'($urandom());
		w.sz       = R_W'($urandom());
		w.axis     = $urandom_range(0, 3);
		return w;
	endfunction

	function automatic cull_word_t coef_word(input logic [PLANE_IDX_W-1:0] plane,
			input logic [COEF_IDX_W-1:0] sel, input logic signed [Q_W-1:0] value);
		cull_word_t w;
		w = random_word();
		w.op       = OP_WRITE;
		w.plane    = plane;
		w.coef_sel = sel;
		w.coef     = value;
		return w;
	endfunction

	function automatic cull_word_t sphere_word(input logic signed [Q_W-1:0] x,
			input logic signed [Q_W-1:0] y, input logic signed [Q_W-1:0] z,
			input logic [R_W-1:0] base, input logic [R_W-1:0] scale,
			input logic [AXIS_W-1:0] axis);
		cull_word_t w;
		w = random_word();
		w.op   = OP_TEST;
		w.cx   = x;
		w.cy   = y;
		w.cz   = z;
		w.base = base;
		w.axis = axis;
		case (axis)
			AXIS_X:  w.sx = scale;
			AXIS_Y:  w.sy = scale;
			default: w.sz = scale;
		endcase
		return w;
	endfunction

	// drive one word, hold it until taken, update the plane table or queue the class
	task automatic send_word(input cull_word_t w);
		item_valid  <= 1'b1;
		op          <= w.op;
		plane_index <= w.plane;
		coef_index  <= w.coef_sel;
		coef_value  <= w.coef;
		center_x    <= w.cx;
		center_y    <= w.cy;
		center_z    <= w.cz;
		base_radius <= w.base;
		scale_x     <= w.sx;
		scale_y     <= w.sy;
		scale_z     <= w.sz;
		radius_axis <= w.axis;
		do @(posedge clk); while (item_stall !== 1'b0);
		word_count++;
		if (w.op == OP_WRITE) begin
			if (w.plane < PLANE_COUNT)
				plane_coef[w.plane * COEFS_PER_PLANE + w.coef_sel] = w.coef;
		end else begin
			vis_due.push_back('{vis: classify_sphere(w), serial: test_serial});
			test_serial++;
		end
		if (!steady && $urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// axis-aligned box of half-width half, slightly skewed; stops after planes_done planes
	task automatic load_box(input int half, input int planes_done);
		logic signed [Q_W-1:0] vals [COEFS_PER_PLANE];
		int dir;
		for (int p = 0; p < planes_done; p++) begin
			foreach (vals[k])
				vals[k] = ($urandom_range(0, 3) == 0) ? jitter(256) : 0;
			dir = (p % 2 == 0) ? -1 : 1;
			vals[(p / 2) % 3] = dir * 65536 + jitter(64);
			vals[COEF_D] = half + jitter(half / 8);
			for (int k = 0; k < COEFS_PER_PLANE; k++) begin
				send_word(coef_word(p, k, vals[k]));
				if ($urandom_range(0, 15) == 0)
					send_word(coef_word($urandom_range(PLANE_COUNT, 7),
						$urandom_range(0, 3), $urandom()));
			end
		end
	endtask

	task automatic probe_spheres(input int half, input int count);
		int reach;
		cull_word_t w;
		reach = half + half / 2;
		repeat (count) begin
			case ($urandom_range(0, 15))
				0, 1: begin
					w = random_word();
					w.op = OP_TEST;
				end
				2: w = coef_word($urandom_range(0, PLANE_COUNT - 1), $urandom_range(0, 3),
					jitter(half));
				default: w = sphere_word(jitter(reach), jitter(reach), jitter(reach),
					$urandom_range(0, half / 3), $urandom_range(0, 3 * 65536),
					$urandom_range(0, 3));
			endcase
			send_word(w);
		end
	endtask

	// all planes zero after reset: every distance is zero
	task automatic test_cleared_table();
		send_word(sphere_word(Q_MIN, Q_MAX, 0, 0, R_ONE, AXIS_X));
		send_word(sphere_word(Q_MAX, Q_MIN, Q_MAX, R_MAX, R_MAX, AXIS_Y));
	endtask

	task automatic test_boundaries();
		for (int p = 0; p < PLANE_COUNT; p++)
			send_word(coef_word(p, COEF_D, ONE));
		send_word(coef_word(PLANE_COUNT, COEF_D, -ONE));
		send_word(coef_word({PLANE_IDX_W{1'b1}}, COEF_A, Q_MIN));
		send_word(sphere_word(0, 0, 0, R_ONE, R_HALF, AXIS_Z_ALIAS));
		send_word(sphere_word(0, 0, 0, R_ONE, R_ONE, AXIS_Y));
		send_word(coef_word(4, COEF_D, -ONE));
		send_word(sphere_word(0, 0, 0, R_ONE, R_ONE, AXIS_Z_SEL));
		send_word(sphere_word(0, 0, 0, R_ONE, R_TWO, AXIS_X));
	endtask

	task automatic test_extremes();
		send_word(coef_word(PLANE_COUNT - 1, COEF_A, Q_MAX));
		send_word(coef_word(PLANE_COUNT - 1, COEF_B, Q_MIN));
		send_word(coef_word(PLANE_COUNT - 1, COEF_C, Q_MAX));
		send_word(coef_word(PLANE_COUNT - 1, COEF_D, Q_MIN));
		send_word(sphere_word(Q_MIN, Q_MAX, Q_MIN, R_ONE, R_ONE, AXIS_Z_SEL));
		send_word(sphere_word(Q_MAX, Q_MIN, Q_MAX, R_MAX, R_MAX, AXIS_X));
	endtask

	task automatic test_random_frusta();
		int half;
		half = 1 << 20;
		while (word_count < RANDOM_UNTIL) begin
			case ($urandom_range(0, 2))
				0:       gap_pct = 0;
				1:       gap_pct = 12;
				default: gap_pct = 45;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					half = $urandom_range(65536, 1 << 26);
					load_box(half, PLANE_COUNT);
					probe_spheres(half, $urandom_range(5, 30));
				end
				6, 7: begin
					repeat ($urandom_range(1, 4))
						send_word(coef_word($urandom_range(0, PLANE_COUNT - 1),
							$urandom_range(0, 3), jitter(half)));
					probe_spheres(half, $urandom_range(5, 15));
				end
				8: repeat ($urandom_range(5, 20)) send_word(random_word());
				default: begin
					load_box(half, $urandom_range(1, PLANE_COUNT - 1));
					probe_spheres(half, $urandom_range(5, 15));
				end
			endcase
		end
	endtask

	task automatic test_streaming();
		int half;
		steady = 1'b1;
		half = $urandom_range(1 << 18, 1 << 24);
		load_box(half, PLANE_COUNT);
		probe_spheres(half, 80);
	endtask

	always @(posedge clk) begin
		vis_due_t head;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (vis_due.size() == 0) begin
				report_mismatch($sformatf("visibility %0d with no test pending", visibility));
			end else begin
				head = vis_due.pop_front();
				if (visibility !== head.vis)
					report_mismatch($sformatf("test %0d: visibility %0d, predicted %0d",
						head.serial, visibility, head.vis));
			end
		end
		if (steady) begin
			result_stall <= 1'b0;
		end else if (rx_left > 0) begin
			rx_left--;
		end else if ($urandom_range(0, 2) == 0) begin
			result_stall <= 1'b1;
			rx_left = $urandom_range(0, 17);
		end else begin
			result_stall <= 1'b0;
			rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cleared_table();
		test_boundaries();
		test_extremes();
		test_random_frusta();
		test_streaming();
		item_valid <= 1'b0;
		while (vis_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
